### rtl/ppr_push_engine_top_assert.svh
// Assertion macros for the push engine top level.
`ifndef PPR_PUSH_ENGINE_TOP_ASSERT_SVH
`define PPR_PUSH_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define PPR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define PPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/ppr_pkg.sv
// Shared constants, command codes and controller/datapath types of the push engine.
package ppr_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 8192;
    localparam int VAL_W     = 31;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int EDGE_W    = $clog2(MAX_EDGES);
    localparam int OFF_W     = EDGE_W + 1;
    localparam int OFFI_W    = NODE_W + 1;
    localparam int CNT_W     = NODE_W + 1;
    localparam int FILL_W    = NODE_W + 1;
    localparam int THR_W     = VAL_W + OFF_W;
    localparam int STEP_W    = 30;
    localparam int ALPHA_W   = 16;
    localparam int CMD_W     = 3;
    localparam int SLOT_W    = 14;
    localparam int CFG_IDX_W = 2;

    localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_WR_OFF = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WR_NBR = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WR_RES = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RUN    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PUSH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES     = 2'd3;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_WRITE,
        OP_READ_ADDR,
        OP_READ_CAP,
        OP_CLR_INIT,
        OP_CLR_STEP,
        OP_RUN_INIT,
        OP_SCAN_SEL,
        OP_DEG_A,
        OP_DEG_B,
        OP_DEG_C,
        OP_DEG_M,
        OP_SCAN_TEST,
        OP_POP,
        OP_POP_CAP,
        OP_KEEP,
        OP_GAIN,
        OP_RANK,
        OP_SHARE,
        OP_EDGE_RD,
        OP_EDGE_CAP,
        OP_SPREAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ppr_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             cnt_last;
        logic             scan_more;
        logic             pop_ok;
        logic             deg_zero;
        logic             div_done;
        logic             edge_more;
    } ppr_stat_t;

endpackage

### rtl/ppr_push_engine_top.sv
// Top level of the personalized PageRank push engine.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------------
//  command  | start, busy               | cmd, slot, word
//  result   | done (one-cycle strobe)   | rank_value, residual_value, steps_taken, saturated
//  config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// Writes and unused codes finish in the dispatch state, a read in a further capture state.
// A clear zeroes one value-store entry per cycle through all 1024 nodes.
// A run scans each node through the degree lookup and threshold test, then pops queued nodes;
// a push with nonzero degree adds a divide wait, a final edge check and a spread per neighbour.
// After reset a clearing pass zeroes residuals and ranks with busy high.
// The result strobe cannot be held off; config is always ready.
`include "ppr_push_engine_top_assert.svh"

module ppr_push_engine_top import ppr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [VAL_W-1:0]     word,
    output logic                 done,
    output logic [VAL_W-1:0]     rank_value,
    output logic [VAL_W-1:0]     residual_value,
    output logic [STEP_W-1:0]    steps_taken,
    output logic                 saturated,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data
);

    ppr_ctl_t  ctl;
    ppr_stat_t stat;

    assign cfg_ready = 1'b1;

    ppr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    ppr_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .cmd            (cmd),
        .slot           (slot),
        .word           (word),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rank_value     (rank_value),
        .residual_value (residual_value),
        .steps_taken    (steps_taken),
        .saturated      (saturated)
    );

    `PPR_ASSERT_IMPL(a_done_when_idle, done, !busy)
    `PPR_ASSERT_NEXT(a_transfer_goes_busy, start && !busy, busy)
    `PPR_ASSERT_NEXT(a_done_single, done, !done)
    `PPR_ASSERT_IMPL(a_divide_in_run, stat.div_done, busy)

endmodule

### rtl/ppr_div.sv
// Radix-2 restoring divider: one quotient bit per cycle.
module ppr_div import ppr_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VAL_W-1:0] dividend,
    input  logic [OFF_W-1:0] divisor,
    output logic [VAL_W-1:0] quotient,
    output logic             done
);

    localparam int DCNT_W = $clog2(VAL_W);

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [OFF_W-1:0]  rem_reg;
    logic [OFF_W-1:0]  dvs_reg;
    logic [VAL_W-1:0]  quo_reg;

    logic [OFF_W:0] shifted;
    logic [OFF_W:0] diff;
    logic           ge;

    assign shifted = {rem_reg, quo_reg[VAL_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(VAL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[OFF_W-1:0] : shifted[OFF_W-1:0];
            quo_reg <= {quo_reg[VAL_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### rtl/ppr_dp.sv
// Push engine datapath: graph and value stores, work queue, arithmetic and config registers.
module ppr_dp import ppr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ppr_ctl_t             ctl,
    output ppr_stat_t            stat,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [VAL_W-1:0]     word,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    output logic [VAL_W-1:0]     rank_value,
    output logic [VAL_W-1:0]     residual_value,
    output logic [STEP_W-1:0]    steps_taken,
    output logic                 saturated
);

    // stores
    logic [OFF_W-1:0]  off_mem  [MAX_NODES+1];
    logic [NODE_W-1:0] tgt_mem  [MAX_EDGES];
    logic [VAL_W-1:0]  res_mem  [MAX_NODES];
    logic [VAL_W-1:0]  rank_mem [MAX_NODES];
    logic [NODE_W-1:0] que_mem  [MAX_NODES];

    logic [OFF_W-1:0]  off_rd_reg;
    logic [NODE_W-1:0] tgt_rd_reg;
    logic [VAL_W-1:0]  res_rd_reg;
    logic [VAL_W-1:0]  rank_rd_reg;
    logic [NODE_W-1:0] que_rd_reg;

    // configuration
    logic [ALPHA_W-1:0] alpha_reg;
    logic [VAL_W-1:0]   eps_reg;
    logic [STEP_W-1:0]  max_push_reg;
    logic [CNT_W-1:0]   node_count_reg;

    // control state
    logic [CNT_W-1:0]  cnt_reg;
    logic [NODE_W-1:0] head_reg;
    logic [NODE_W-1:0] tail_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [STEP_W-1:0] step_reg;
    logic              ovf_reg;

    // payload
    logic [CMD_W-1:0]  cmd_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [VAL_W-1:0]  word_reg;
    logic [NODE_W-1:0] node_reg;
    logic [OFF_W-1:0]  offa_reg;
    logic [OFF_W-1:0]  offb_reg;
    logic [OFF_W-1:0]  deg_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [OFF_W-1:0]  edge_reg;
    logic [OFF_W-1:0]  eend_reg;
    logic [VAL_W-1:0]  surp_reg;
    logic [VAL_W-1:0]  gain_reg;
    logic [VAL_W-1:0]  spr_reg;
    logic [VAL_W-1:0]  share_reg;
    logic [VAL_W-1:0]  rank_out_reg;
    logic [VAL_W-1:0]  res_out_reg;

    // memory ports
    logic              off_re, off_we;
    logic [OFFI_W-1:0] off_ra, off_wa;
    logic [OFF_W-1:0]  off_wd;
    logic              tgt_re, tgt_we;
    logic [EDGE_W-1:0] tgt_ra, tgt_wa;
    logic              val_re;
    logic [NODE_W-1:0] val_ra;
    logic              res_we, rank_we;
    logic [NODE_W-1:0] res_wa, rank_wa;
    logic [VAL_W-1:0]  res_wd, rank_wd;
    logic              que_re, push_en;

    // arithmetic
    logic [OFFI_W-1:0]    node_p1;
    logic [CNT_W-1:0]     n_lim;
    logic [THR_W-1:0]     keep_full;
    logic                 res_gt_keep;
    logic                 res_gt_thr;
    logic [VAL_W:0]       sp_sum;
    logic [VAL_W-1:0]     sp_new;
    logic                 sp_new_gt;
    logic [VAL_W:0]       rk_sum;
    logic [VAL_W-1:0]     rk_new;
    logic                 q_room;
    logic [THR_W-1:0]     thr_prod;
    logic [ALPHA_W:0]     one_minus_a;
    logic [ALPHA_W+VAL_W:0]   gain_prod;
    logic [ALPHA_W+VAL_W-1:0] spr_prod;
    logic                 div_start;
    logic [VAL_W-1:0]     div_quo;
    logic                 div_done;

    assign node_p1     = {1'b0, node_reg} + OFFI_W'(1);
    assign n_lim       = (node_count_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                              : node_count_reg;
    assign keep_full   = thr_reg >> 1;
    assign res_gt_keep = THR_W'(res_rd_reg) > keep_full;
    assign res_gt_thr  = THR_W'(res_rd_reg) > thr_reg;
    assign sp_sum      = {1'b0, res_rd_reg} + {1'b0, share_reg};
    assign sp_new      = sp_sum[VAL_W] ? VALUE_MAX : sp_sum[VAL_W-1:0];
    assign sp_new_gt   = THR_W'(sp_new) > thr_reg;
    assign rk_sum      = {1'b0, rank_rd_reg} + {1'b0, gain_reg};
    assign rk_new      = rk_sum[VAL_W] ? VALUE_MAX : rk_sum[VAL_W-1:0];
    assign q_room      = fill_reg != FILL_W'(MAX_NODES);
    assign thr_prod    = THR_W'(eps_reg) * THR_W'(deg_reg);
    assign one_minus_a = (ALPHA_W+1)'(1 << ALPHA_W) - {1'b0, alpha_reg};
    assign gain_prod   = (ALPHA_W+VAL_W+1)'(one_minus_a) * (ALPHA_W+VAL_W+1)'(surp_reg);
    assign spr_prod    = (ALPHA_W+VAL_W)'(alpha_reg) * (ALPHA_W+VAL_W)'(surp_reg);
    assign div_start   = (ctl.op == OP_RANK) && (deg_reg != '0);

    // queue a node above its threshold at scan or on crossing it in a spread; drop when full
    assign push_en = q_room &&
                     (((ctl.op == OP_SCAN_TEST) && res_gt_thr) ||
                      ((ctl.op == OP_SPREAD) && sp_new_gt && !res_gt_thr));
    assign que_re  = ctl.op == OP_POP;

    assign off_re = (ctl.op == OP_DEG_A) || (ctl.op == OP_DEG_B);
    assign off_ra = (ctl.op == OP_DEG_A) ? {1'b0, node_reg} : node_p1;
    assign off_we = (ctl.op == OP_WRITE) && (cmd_reg == CMD_WR_OFF) &&
                    (slot_reg <= SLOT_W'(MAX_NODES));
    assign off_wa = slot_reg[OFFI_W-1:0];
    assign off_wd = (word_reg > VAL_W'(MAX_EDGES)) ? OFF_W'(MAX_EDGES) : word_reg[OFF_W-1:0];

    assign tgt_re = ctl.op == OP_EDGE_RD;
    assign tgt_ra = edge_reg[EDGE_W-1:0];
    assign tgt_we = (ctl.op == OP_WRITE) && (cmd_reg == CMD_WR_NBR) &&
                    (slot_reg < SLOT_W'(MAX_EDGES));
    assign tgt_wa = slot_reg[EDGE_W-1:0];

    assign val_re = (ctl.op == OP_DEG_B) || (ctl.op == OP_READ_ADDR);
    assign val_ra = (ctl.op == OP_DEG_B) ? node_reg : slot_reg[NODE_W-1:0];

    always_comb
    begin
        res_we  = 1'b0;
        res_wa  = node_reg;
        res_wd  = sp_new;
        rank_we = 1'b0;
        rank_wa = node_reg;
        rank_wd = rk_new;
        unique case (ctl.op)
            OP_WRITE:
            begin
                res_we = (cmd_reg == CMD_WR_RES) && (slot_reg < SLOT_W'(MAX_NODES));
                res_wa = slot_reg[NODE_W-1:0];
                res_wd = word_reg;
            end
            OP_KEEP:
            begin
                res_we = res_gt_keep;
                res_wd = keep_full[VAL_W-1:0];
            end
            OP_SPREAD:
            begin
                res_we = 1'b1;
            end
            OP_RANK:
            begin
                rank_we = 1'b1;
            end
            OP_CLR_STEP:
            begin
                res_we  = 1'b1;
                res_wa  = cnt_reg[NODE_W-1:0];
                res_wd  = '0;
                rank_we = 1'b1;
                rank_wa = cnt_reg[NODE_W-1:0];
                rank_wd = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (off_we)
            off_mem[off_wa] <= off_wd;
        if (off_re)
            off_rd_reg <= off_mem[off_ra];
    end

    always_ff @(posedge clk)
    begin
        if (tgt_we)
            tgt_mem[tgt_wa] <= word_reg[NODE_W-1:0];
        if (tgt_re)
            tgt_rd_reg <= tgt_mem[tgt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
            res_mem[res_wa] <= res_wd;
        if (val_re)
            res_rd_reg <= res_mem[val_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
            rank_mem[rank_wa] <= rank_wd;
        if (val_re)
            rank_rd_reg <= rank_mem[val_ra];
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
            que_mem[tail_reg] <= node_reg;
        if (que_re)
            que_rd_reg <= que_mem[head_reg];
    end

    ppr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (spr_reg),
        .divisor  (deg_reg),
        .quotient (div_quo),
        .done     (div_done)
    );

    // configuration registers and run bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg      <= ALPHA_W'(64881);
            eps_reg        <= VAL_W'(214748);
            max_push_reg   <= STEP_W'(1000000);
            node_count_reg <= CNT_W'(1024);
            cnt_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            step_reg       <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ALPHA:     alpha_reg      <= cfg_data[ALPHA_W-1:0];
                    CFG_THRESHOLD: eps_reg        <= cfg_data;
                    CFG_MAX_PUSH:  max_push_reg   <= cfg_data[STEP_W-1:0];
                    CFG_NODES:     node_count_reg <= cfg_data[CNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (push_en)
            begin
                tail_reg <= tail_reg + 1'b1;
                fill_reg <= fill_reg + 1'b1;
            end
            unique case (ctl.op)
                OP_CLR_INIT:
                begin
                    cnt_reg  <= '0;
                    head_reg <= '0;
                    tail_reg <= '0;
                    fill_reg <= '0;
                end
                OP_RUN_INIT:
                begin
                    cnt_reg  <= '0;
                    head_reg <= '0;
                    tail_reg <= '0;
                    fill_reg <= '0;
                    step_reg <= '0;
                    ovf_reg  <= 1'b0;
                end
                OP_CLR_STEP, OP_SCAN_TEST:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                OP_POP:
                begin
                    head_reg <= head_reg + 1'b1;
                    fill_reg <= fill_reg - 1'b1;
                    step_reg <= step_reg + 1'b1;
                end
                OP_RANK:
                begin
                    if (rk_sum[VAL_W])
                        ovf_reg <= 1'b1;
                end
                OP_SPREAD:
                begin
                    if (sp_sum[VAL_W])
                        ovf_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            OP_LATCH:
            begin
                cmd_reg      <= cmd;
                slot_reg     <= slot;
                word_reg     <= word;
                rank_out_reg <= '0;
                res_out_reg  <= '0;
            end
            OP_READ_CAP:
            begin
                if (slot_reg < SLOT_W'(MAX_NODES))
                begin
                    rank_out_reg <= rank_rd_reg;
                    res_out_reg  <= res_rd_reg;
                end
            end
            OP_SCAN_SEL: node_reg <= cnt_reg[NODE_W-1:0];
            OP_POP_CAP:  node_reg <= que_rd_reg;
            OP_EDGE_CAP: node_reg <= tgt_rd_reg;
            OP_DEG_B:    offa_reg <= off_rd_reg;
            OP_DEG_C:
            begin
                offb_reg <= off_rd_reg;
                deg_reg  <= (off_rd_reg > offa_reg) ? off_rd_reg - offa_reg : '0;
            end
            OP_DEG_M:    thr_reg <= thr_prod;
            OP_KEEP:
            begin
                edge_reg <= offa_reg;
                eend_reg <= offb_reg;
                surp_reg <= res_gt_keep ? res_rd_reg - keep_full[VAL_W-1:0] : '0;
            end
            OP_GAIN:
            begin
                gain_reg <= gain_prod[ALPHA_W+VAL_W-1:ALPHA_W];
                spr_reg  <= spr_prod[ALPHA_W+VAL_W-1:ALPHA_W];
            end
            OP_SHARE:    share_reg <= div_quo;
            OP_EDGE_RD:  edge_reg  <= edge_reg + 1'b1;
            default:
            begin
            end
        endcase
    end

    assign stat.cmd       = cmd_reg;
    assign stat.cnt_last  = cnt_reg == CNT_W'(MAX_NODES - 1);
    assign stat.scan_more = cnt_reg < n_lim;
    assign stat.pop_ok    = (fill_reg != '0) && (step_reg < max_push_reg);
    assign stat.deg_zero  = deg_reg == '0;
    assign stat.div_done  = div_done;
    assign stat.edge_more = edge_reg < eend_reg;

    assign rank_value     = rank_out_reg;
    assign residual_value = res_out_reg;
    assign steps_taken    = step_reg;
    assign saturated      = ovf_reg;

endmodule

### rtl/ppr_ctrl.sv
// Push engine controller: sequences commands, scan, pops and neighbour spreads.
module ppr_ctrl import ppr_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  ppr_stat_t stat,
    output ppr_ctl_t  ctl,
    output logic      busy,
    output logic      done
);

    typedef enum logic [4:0] {
        S_RST_CLR,
        S_IDLE,
        S_DISPATCH,
        S_READ_CAP,
        S_CLEAR,
        S_SCAN_CHK,
        S_DEG_A,
        S_DEG_B,
        S_DEG_C,
        S_DEG_M,
        S_SCAN_TEST,
        S_POP_CHK,
        S_POP_CAP,
        S_KEEP,
        S_GAIN,
        S_RANK,
        S_DIV_WAIT,
        S_EDGE_CHK,
        S_EDGE_CAP,
        S_SPREAD
    } state_t;

    typedef enum logic [1:0] {
        CTX_SCAN,
        CTX_POP,
        CTX_EDGE
    } ctx_t;

    state_t state_reg, state_next;
    ctx_t   ctx_reg, ctx_next;
    logic   done_reg, done_next;
    dp_op_t op;

    always_comb
    begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        done_next  = 1'b0;
        op         = OP_NOP;
        unique case (state_reg)
            S_RST_CLR:
            begin
                op = OP_CLR_STEP;
                if (stat.cnt_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op         = OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.cmd)
                    CMD_WR_OFF, CMD_WR_NBR, CMD_WR_RES:
                    begin
                        op         = OP_WRITE;
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                    CMD_RUN:
                    begin
                        op         = OP_RUN_INIT;
                        state_next = S_SCAN_CHK;
                    end
                    CMD_READ:
                    begin
                        op         = OP_READ_ADDR;
                        state_next = S_READ_CAP;
                    end
                    CMD_CLEAR:
                    begin
                        op         = OP_CLR_INIT;
                        state_next = S_CLEAR;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                endcase
            end
            S_READ_CAP:
            begin
                op         = OP_READ_CAP;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_CLEAR:
            begin
                op = OP_CLR_STEP;
                if (stat.cnt_last)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_SCAN_CHK:
            begin
                if (stat.scan_more)
                begin
                    op         = OP_SCAN_SEL;
                    ctx_next   = CTX_SCAN;
                    state_next = S_DEG_A;
                end
                else
                    state_next = S_POP_CHK;
            end
            S_DEG_A:
            begin
                op         = OP_DEG_A;
                state_next = S_DEG_B;
            end
            S_DEG_B:
            begin
                op         = OP_DEG_B;
                state_next = S_DEG_C;
            end
            S_DEG_C:
            begin
                op         = OP_DEG_C;
                state_next = S_DEG_M;
            end
            S_DEG_M:
            begin
                op = OP_DEG_M;
                unique case (ctx_reg)
                    CTX_SCAN: state_next = S_SCAN_TEST;
                    CTX_POP:  state_next = S_KEEP;
                    default:  state_next = S_SPREAD;
                endcase
            end
            S_SCAN_TEST:
            begin
                op         = OP_SCAN_TEST;
                state_next = S_SCAN_CHK;
            end
            S_POP_CHK:
            begin
                if (stat.pop_ok)
                begin
                    op         = OP_POP;
                    state_next = S_POP_CAP;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_POP_CAP:
            begin
                op         = OP_POP_CAP;
                ctx_next   = CTX_POP;
                state_next = S_DEG_A;
            end
            S_KEEP:
            begin
                op         = OP_KEEP;
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                op         = OP_GAIN;
                state_next = S_RANK;
            end
            S_RANK:
            begin
                op         = OP_RANK;
                state_next = stat.deg_zero ? S_POP_CHK : S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    op         = OP_SHARE;
                    state_next = S_EDGE_CHK;
                end
            end
            S_EDGE_CHK:
            begin
                if (stat.edge_more)
                begin
                    op         = OP_EDGE_RD;
                    state_next = S_EDGE_CAP;
                end
                else
                    state_next = S_POP_CHK;
            end
            S_EDGE_CAP:
            begin
                op         = OP_EDGE_CAP;
                ctx_next   = CTX_EDGE;
                state_next = S_DEG_A;
            end
            S_SPREAD:
            begin
                op         = OP_SPREAD;
                state_next = S_EDGE_CHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RST_CLR;
            ctx_reg   <= CTX_SCAN;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
            done_reg  <= done_next;
        end
    end

    assign ctl.op = op;
    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;

endmodule

### test/ppr_push_engine_top_tb.sv
// Self-checking testbench for the personalized PageRank push engine top level.
module ppr_push_engine_top_tb import ppr_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
    localparam int GRAPH_EDGES  = 256;
    localparam int LOCAL_NODES  = 33;
    localparam int OFFSET_SLOTS = 64;

    typedef struct {
        logic [CMD_W-1:0]  op;
        logic [SLOT_W-1:0] idx;
        logic [VAL_W-1:0]  val;
        bit                typed;
        logic [VAL_W-1:0]  rk;
        logic [VAL_W-1:0]  rs;
    } cmd_row_t;

    typedef struct {
        logic [VAL_W-1:0]  rk;
        logic [VAL_W-1:0]  rs;
        logic [STEP_W-1:0] steps;
        logic              sat;
    } node_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [CMD_W-1:0]     cmd;
    logic [SLOT_W-1:0]    slot;
    logic [VAL_W-1:0]     word;
    logic                 done;
    logic [VAL_W-1:0]     rank_value;
    logic [VAL_W-1:0]     residual_value;
    logic [STEP_W-1:0]    steps_taken;
    logic                 saturated;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAL_W-1:0]     cfg_data;

    ppr_push_engine_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .slot(slot), .word(word), .done(done),
        .rank_value(rank_value), .residual_value(residual_value),
        .steps_taken(steps_taken), .saturated(saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state
    longint unsigned alpha_q16, eps_q31, push_limit, nodes_used;
    int unsigned     offs [0:MAX_NODES];
    int unsigned     nbr [0:MAX_EDGES-1];
    longint unsigned resid [0:MAX_NODES-1];
    longint unsigned rank_acc [0:MAX_NODES-1];
    int unsigned     fifo [0:MAX_NODES-1];
    int unsigned     q_head, q_tail, q_fill;
    int unsigned     pass_steps;
    bit              clipped;

    node_result_t pending_results[$];
    int           mismatches;
    bit           lost_result;
    int           idle_pct;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned degree_of(int unsigned u);
        return offs[u+1] > offs[u] ? longint'(offs[u+1] - offs[u]) : 0;
    endfunction

    function automatic longint unsigned clip_sum(longint unsigned x, longint unsigned y);
        longint unsigned s;
        s = x + y;
        if (s > longint'(VALUE_MAX))
        begin
            clipped = 1'b1;
            s = longint'(VALUE_MAX);
        end
        return s;
    endfunction

    function automatic void enqueue_node(int unsigned n);
        if (q_fill >= MAX_NODES)
            return;
        fifo[q_tail] = n;
        q_tail = (q_tail + 1 == MAX_NODES) ? 0 : q_tail + 1;
        q_fill++;
    endfunction

    function automatic void run_push_pass();
        longint unsigned d, keep, surplus, share, thr, old, nw;
        int unsigned     n, u, x;
        q_head = 0;
        q_tail = 0;
        q_fill = 0;
        pass_steps = 0;
        clipped = 1'b0;
        n = nodes_used > MAX_NODES ? MAX_NODES : int'(nodes_used);
        for (u = 0; u < n; u++)
            if (resid[u] > eps_q31 * degree_of(u))
                enqueue_node(u);
        while (q_fill > 0 && pass_steps < push_limit)
        begin
            pass_steps++;
            u = fifo[q_head];
            q_head = (q_head + 1 == MAX_NODES) ? 0 : q_head + 1;
            q_fill--;
            d = degree_of(u);
            keep = (eps_q31 * d) >> 1;
            surplus = 0;
            if (resid[u] > keep)
            begin
                surplus = resid[u] - keep;
                resid[u] = keep;
            end
            rank_acc[u] = clip_sum(rank_acc[u], ((65536 - alpha_q16) * surplus) >> 16);
            if (d > 0)
            begin
                share = ((alpha_q16 * surplus) >> 16) / d;
                for (int unsigned e = offs[u]; e < offs[u+1]; e++)
                begin
                    x = nbr[e];
                    thr = eps_q31 * degree_of(x);
                    old = resid[x];
                    nw = clip_sum(old, share);
                    resid[x] = nw;
                    if (nw > thr && old <= thr)
                        enqueue_node(x);
                end
            end
        end
    endfunction

    function automatic node_result_t apply_command(cmd_row_t r);
        node_result_t o;
        int unsigned  s;
        o.rk = '0;
        o.rs = '0;
        s = r.idx;
        case (r.op)
            CMD_WR_OFF: if (s <= MAX_NODES) offs[s] = r.val > MAX_EDGES ? MAX_EDGES : 32'(r.val);
            CMD_WR_NBR: if (s < MAX_EDGES) nbr[s] = 32'(r.val) % MAX_NODES;
            CMD_WR_RES: if (s < MAX_NODES) resid[s] = 64'(r.val);
            CMD_RUN:    run_push_pass();
            CMD_READ:
                if (s < MAX_NODES)
                begin
                    o.rk = rank_acc[s][VAL_W-1:0];
                    o.rs = resid[s][VAL_W-1:0];
                end
            CMD_CLEAR:
            begin
                for (int i = 0; i < MAX_NODES; i++)
                begin
                    resid[i] = 0;
                    rank_acc[i] = 0;
                end
                q_head = 0;
                q_tail = 0;
                q_fill = 0;
            end
            default: ;
        endcase
        o.steps = pass_steps[STEP_W-1:0];
        o.sat = clipped;
        return o;
    endfunction

    // Drive one command from a falling edge; hold until the transfer, then maybe idle.
    task automatic issue(cmd_row_t r);
        node_result_t o;
        cmd <= r.op;
        slot <= r.idx;
        word <= r.val;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        o = apply_command(r);
        if (r.typed)
        begin
            o.rk = r.rk;
            o.rs = r.rs;
            o.steps = '0;
            o.sat = 1'b0;
        end
        pending_results = {pending_results, o};
        @(negedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic issue_plain(logic [CMD_W-1:0] op, int unsigned s, int unsigned v);
        cmd_row_t r;
        r = '{op, s[SLOT_W-1:0], v[VAL_W-1:0], 1'b0, '0, '0};
        issue(r);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
        cfg_index <= idx;
        cfg_data <= v[VAL_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_ALPHA:     alpha_q16 = 64'(v[ALPHA_W-1:0]);
            CFG_THRESHOLD: eps_q31 = 64'(v[VAL_W-1:0]);
            CFG_MAX_PUSH:  push_limit = 64'(v[STEP_W-1:0]);
            CFG_NODES:     nodes_used = 64'(v[CNT_W-1:0]);
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drain all results, then reprogram every register.
    task automatic set_phase(int unsigned a, int unsigned t, int unsigned m, int unsigned n);
        start <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(posedge clk);
        @(negedge clk);
        write_reg(CFG_ALPHA, a);
        write_reg(CFG_THRESHOLD, t);
        write_reg(CFG_MAX_PUSH, m);
        write_reg(CFG_NODES, n);
    endtask

    always @(posedge clk)
    begin
        node_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                lost_result = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t", $realtime);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rank_value !== want.rk || residual_value !== want.rs ||
                    steps_taken !== want.steps || saturated !== want.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch %0t: exp %h %h %0d %b got %h %h %0d %b",
                                 $realtime, want.rk, want.rs, want.steps, want.sat,
                                 rank_value, residual_value, steps_taken, saturated);
                end
            end
        end
    end

    initial
    begin
        #2s;
        $display("[ppr_push_engine_top] ERROR");
        $finish;
    end

    initial
    begin
        cmd_row_t    dir_rows[$];
        int unsigned roll, s, phase_alpha[5], phase_thr[5], phase_max[5], phase_nodes[5];
        int unsigned phase_idle[5];
        int unsigned v;

        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        slot = '0;
        word = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        lost_result = 1'b0;
        idle_pct = 0;
        alpha_q16 = 64881;
        eps_q31 = 214748;
        push_limit = 1000000;
        nodes_used = 1024;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            resid[i] = 0;
            rank_acc[i] = 0;
        end
        q_head = 0;
        q_tail = 0;
        q_fill = 0;
        pass_steps = 0;
        clipped = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Load a graph: a small dense region of degree-four nodes, every node past it with degree zero.
        for (int i = 0; i < OFFSET_SLOTS; i++)
            issue_plain(CMD_WR_OFF, i, i < LOCAL_NODES ? 4 * i : 4 * (LOCAL_NODES - 1));
        for (int e = 0; e < GRAPH_EDGES; e++)
            issue_plain(CMD_WR_NBR, e, $urandom_range(0, 40));

        set_phase(32768, 1 << 24, 64, 40);

        dir_rows = '{
            '{CMD_READ,    14'd0,     31'd0,          1'b1, 31'd0, 31'd0},
            '{CMD_READ,    14'h3FFF,  31'd0,          1'b1, 31'd0, 31'd0},
            '{CMD_SPARE_A, 14'd5,     31'h7FFFFFFF,   1'b1, 31'd0, 31'd0},
            '{CMD_SPARE_B, 14'd5,     31'd9,          1'b1, 31'd0, 31'd0},
            '{CMD_WR_RES,  14'd1023,  31'h7FFFFFFF,   1'b1, 31'd0, 31'd0},
            '{CMD_READ,    14'd1023,  31'd0,          1'b1, 31'd0, 31'h7FFFFFFF},
            '{CMD_WR_RES,  14'h3FFF,  31'd5,          1'b1, 31'd0, 31'd0},
            '{CMD_WR_OFF,  14'd1024,  31'h7FFFFFFF,   1'b1, 31'd0, 31'd0},
            '{CMD_WR_OFF,  14'd1025,  31'd0,          1'b1, 31'd0, 31'd0},
            '{CMD_WR_OFF,  14'd1024,  31'd128,        1'b1, 31'd0, 31'd0},
            '{CMD_WR_NBR,  14'd8191,  31'h7FFFFFFF,   1'b1, 31'd0, 31'd0},
            '{CMD_WR_NBR,  14'h3FFF,  31'd3,          1'b1, 31'd0, 31'd0},
            '{CMD_CLEAR,   14'd0,     31'd0,          1'b1, 31'd0, 31'd0},
            '{CMD_READ,    14'd1023,  31'd0,          1'b1, 31'd0, 31'd0},
            // reversed offsets around node 3, a degree-zero seed at node 40
            '{CMD_WR_OFF,  14'd3,     31'd100,        1'b0, 31'd0, 31'd0},
            '{CMD_WR_OFF,  14'd4,     31'd50,         1'b0, 31'd0, 31'd0},
            '{CMD_WR_RES,  14'd0,     31'h7FFFFFFF,   1'b0, 31'd0, 31'd0},
            '{CMD_WR_RES,  14'd3,     31'h20000000,   1'b0, 31'd0, 31'd0},
            '{CMD_WR_RES,  14'd40,    31'h10000000,   1'b0, 31'd0, 31'd0},
            '{CMD_WR_RES,  14'd10,    31'h40000000,   1'b0, 31'd0, 31'd0},
            '{CMD_RUN,     14'd0,     31'd0,          1'b0, 31'd0, 31'd0},
            '{CMD_READ,    14'd0,     31'd0,          1'b0, 31'd0, 31'd0},
            '{CMD_READ,    14'd3,     31'd0,          1'b0, 31'd0, 31'd0},
            '{CMD_READ,    14'd40,    31'd0,          1'b0, 31'd0, 31'd0},
            '{CMD_RUN,     14'd0,     31'd0,          1'b0, 31'd0, 31'd0}
        };
        foreach (dir_rows[i])
            issue(dir_rows[i]);

        // scans stay inside the written offset slots
        phase_alpha = '{32768, 0, 65535, 50000, 20000};
        phase_thr   = '{1 << 24, 0, 32'h7FFFFFFF, 1 << 20, 1 << 22};
        phase_max   = '{64, 1, 32'h3FFFFFFF, 300, 1000};
        phase_nodes = '{40, 1, OFFSET_SLOTS - 1, 33, OFFSET_SLOTS - 1};
        phase_idle  = '{0, 78, 14, 78, 0};
        for (int p = 0; p < 5; p++)
        begin
            set_phase(phase_alpha[p], phase_thr[p], phase_max[p], phase_nodes[p]);
            idle_pct = phase_idle[p];
            for (int k = 0; k < 160; k++)
            begin
                roll = $urandom_range(99);
                s = ($urandom_range(9) == 0) ? $urandom_range(16383) : $urandom_range(0, 40);
                if (roll < 30)
                    issue_plain(CMD_WR_RES, s, $urandom);
                else if (roll < 58)
                    issue_plain(CMD_READ, s, $urandom);
                else if (roll < 68)
                begin
                    // keep every offset inside the written edge range
                    s = $urandom_range(0, LOCAL_NODES);
                    v = ($urandom_range(19) == 0) ? $urandom_range(0, GRAPH_EDGES)
                                                  : 4 * s + $urandom_range(0, 6);
                    issue_plain(CMD_WR_OFF, s, v);
                end
                else if (roll < 82)
                begin
                    s = ($urandom_range(9) == 0) ? $urandom_range(16383)
                                                 : $urandom_range(0, GRAPH_EDGES - 1);
                    v = ($urandom & 32'h7FFFFC00) | $urandom_range(0, 40);
                    issue_plain(CMD_WR_NBR, s, v);
                end
                else if (roll < 91)
                    issue_plain(CMD_RUN, $urandom, $urandom);
                else if (roll < 94)
                    issue_plain(CMD_CLEAR, $urandom, $urandom);
                else
                    issue_plain(CMD_W'($urandom_range(CMD_SPARE_A, CMD_SPARE_B)),
                                $urandom, $urandom);
            end
        end

        start <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && !lost_result && pending_results.size() == 0)
            $display("[ppr_push_engine_top] OK");
        else
            $display("[ppr_push_engine_top] ERROR");
        $finish;
    end

endmodule
